// File: design/lsfe_pkg.sv
// ----------------------------------------------------------------------------
// LED strip frame encoder package
// Shared widths, operation codes, sequencer states and the color wheel helper.
// ----------------------------------------------------------------------------
package lsfe_pkg;

  localparam int unsigned STRIP_LENGTH_DEF = 64;
  localparam int unsigned COLOR_W          = 24;
  localparam int unsigned PIX_W            = 8;
  localparam int unsigned WHEEL_W          = 8;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned OP_W             = 3;
  localparam int unsigned BIT_CNT_W        = 5;
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT     = BIT_CNT_W'(COLOR_W - 1);
  localparam logic [BYTE_W-1:0]    ONE_PAT_RST  = 8'd248;
  localparam logic [BYTE_W-1:0]    ZERO_PAT_RST = 8'd192;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_PAT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAT = 1'b1;

  localparam logic [7:0] WHEEL_THIRD     = 8'd85;
  localparam logic [7:0] WHEEL_TWO_THIRD = 8'd170;
  localparam logic [7:0] WHEEL_FULL      = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_SET      = 3'd0,
    OP_WHEEL    = 3'd1,
    OP_FILL     = 3'd2,
    OP_FILL_OFF = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_EMIT     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } sweep_ctrl_t;

  typedef struct packed {
    logic at_end;
    logic in_range;
  } sweep_stat_t;

  // Maps a wheel position onto a GRB color: red to green to blue and back.
  function automatic logic [COLOR_W-1:0] wheel_color(input logic [WHEEL_W-1:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] q3;
    logic [7:0] t;
    logic [7:0] c;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    p = WHEEL_FULL - pos;
    if (p < WHEEL_THIRD) begin
      q = p;
    end else if (p < WHEEL_TWO_THIRD) begin
      q = p - WHEEL_THIRD;
    end else begin
      q = p - WHEEL_TWO_THIRD;
    end
    q3 = {2'b00, q} + {1'b0, q, 1'b0};
    t  = q3[7:0];
    c  = WHEEL_FULL - t;
    if (p < WHEEL_THIRD) begin
      r = c;
      g = 8'd0;
      b = t;
    end else if (p < WHEEL_TWO_THIRD) begin
      r = 8'd0;
      g = t;
      b = c;
    end else begin
      r = t;
      g = c;
      b = 8'd0;
    end
    return {g, r, b};
  endfunction

endpackage

// File: design/lsfe_pixel_store.sv
// ----------------------------------------------------------------------------
// LED strip frame encoder pixel store
// One write port and one registered read port; per-entry valid bits make
// unwritten or cleared entries read as black.
// ----------------------------------------------------------------------------
module lsfe_pixel_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [lsfe_pkg::COLOR_W-1:0] wr_data_i,
  input  logic                        clr_i,
  input  logic                        rd_en_i,
  input  logic [IDX_W-1:0]            rd_addr_i,
  output logic [lsfe_pkg::COLOR_W-1:0] rd_data_o
);
  import lsfe_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  logic [COLOR_W-1:0] rd_raw_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

// File: design/lsfe_sweep_unit.sv
// ----------------------------------------------------------------------------
// LED strip frame encoder sweep unit
// Shared address counter with end-of-run and range compare, used by fills.
// ----------------------------------------------------------------------------
module lsfe_sweep_unit #(
  parameter int unsigned IDX_W = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lsfe_pkg::sweep_ctrl_t    ctrl_i,
  input  logic [IDX_W-1:0]         start_i,
  input  logic [IDX_W-1:0]         stop_i,
  input  logic [lsfe_pkg::PIX_W-1:0] lo_i,
  input  logic [lsfe_pkg::PIX_W-1:0] hi_i,
  output logic [IDX_W-1:0]         idx_o,
  output lsfe_pkg::sweep_stat_t    stat_o
);
  import lsfe_pkg::*;

  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] stop_q, stop_d;
  logic [PIX_W:0]   cnt_ext;

  always_comb begin
    cnt_d  = cnt_q;
    stop_d = stop_q;
    if (ctrl_i.load) begin
      cnt_d  = start_i;
      stop_d = stop_i;
    end else if (ctrl_i.step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      stop_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

  assign cnt_ext         = (PIX_W + 1)'(cnt_q);
  assign idx_o           = cnt_q;
  assign stat_o.at_end   = (cnt_q == stop_q);
  assign stat_o.in_range = (cnt_ext >= {1'b0, lo_i}) && (cnt_ext <= {1'b0, hi_i});

endmodule

// File: design/led_strip_frame_encoder.sv
// ----------------------------------------------------------------------------
// LED strip frame encoder
// Pixel frame store with a small sequencer that writes pixels, fills ranges
// and serializes the frame into one line byte per color bit.
// ----------------------------------------------------------------------------
// Set pixel, wheel pixel, clear and unused codes: the execute state acts, then
// returns to idle. Emit byte: the execute state reads the pixel memory and the
// emit state loads the byte into the output register; the emit state waits only
// while the output stalls. Fill range: the sweep state writes each pixel of the
// range; others-off fill sweeps all STRIP_LENGTH pixels, one memory write per
// cycle through the sweep counter.
// Reset clears all valid bits at once, so the frame reads black right away.
// ----------------------------------------------------------------------------
module led_strip_frame_encoder #(
  parameter int unsigned STRIP_LENGTH = lsfe_pkg::STRIP_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // tdata: first_pixel[7:0], last_pixel[15:8], color[39:16], wheel_position[47:40]
  input  logic [47:0]                   s_tdata_i,
  // tuser: operation[2:0]
  input  logic [lsfe_pkg::OP_W-1:0]     s_tuser_i,
  // Output stream
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // tdata: line_byte[7:0]
  output logic [lsfe_pkg::BYTE_W-1:0]   m_tdata_o,
  // tlast: frame_end
  output logic                          m_tlast_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsfe_pkg::BYTE_W-1:0]   cfg_data_i
);
  import lsfe_pkg::*;

  localparam int unsigned    IDX_W    = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
  localparam logic [PIX_W:0] LEN      = (PIX_W + 1)'(STRIP_LENGTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIP_LENGTH - 1);

  // Sequencer state and latched request.
  state_e             state_q, state_d;
  op_e                op_q;
  logic [PIX_W-1:0]   first_q;
  logic [PIX_W-1:0]   last_q;
  logic [COLOR_W-1:0] color_q;
  logic [WHEEL_W-1:0] wheel_q;

  // Line patterns.
  logic [BYTE_W-1:0]  one_pat_q;
  logic [BYTE_W-1:0]  zero_pat_q;

  // Emission position: pixel, then bit counted from the MSB.
  logic [IDX_W-1:0]     emit_pix_q, emit_pix_d;
  logic [BIT_CNT_W-1:0] emit_bit_q, emit_bit_d;

  // Output register.
  logic               m_valid_q, m_valid_d;
  logic [BYTE_W-1:0]  m_data_q;
  logic               m_last_q;

  // Memory and sweep hookup.
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [COLOR_W-1:0] wr_data;
  logic               clr_all;
  logic               rd_en;
  logic [COLOR_W-1:0] rd_data;
  sweep_ctrl_t        sweep_ctrl;
  sweep_stat_t        sweep_stat;
  logic [IDX_W-1:0]   sweep_start;
  logic [IDX_W-1:0]   sweep_stop;
  logic [IDX_W-1:0]   sweep_idx;

  logic               accept;
  logic               load_out;
  logic               first_fits;
  logic               last_fits;
  logic               pix_bit;
  logic               frame_end;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign first_fits = ({1'b0, first_q} < LEN);
  assign last_fits  = ({1'b0, last_q} < LEN);

  // A fill sweep ends at the last pixel of the range, clipped to the strip; an others-off fill ends at the last pixel.
  assign sweep_start = (op_q == OP_FILL) ? first_q[IDX_W-1:0] : '0;
  assign sweep_stop  = ((op_q == OP_FILL) && last_fits) ? last_q[IDX_W-1:0] : LAST_IDX;

  // Bit selection from the pixel just read; MSB goes first.
  assign pix_bit   = rd_data[LAST_BIT - emit_bit_q];
  assign frame_end = (emit_pix_q == LAST_IDX) && (emit_bit_q == LAST_BIT);

  always_comb begin
    state_d         = state_q;
    wr_en           = 1'b0;
    wr_addr         = first_q[IDX_W-1:0];
    wr_data         = color_q;
    clr_all         = 1'b0;
    rd_en           = 1'b0;
    load_out        = 1'b0;
    sweep_ctrl.load = 1'b0;
    sweep_ctrl.step = 1'b0;
    emit_pix_d      = emit_pix_q;
    emit_bit_d      = emit_bit_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (op_q)
          OP_SET: begin
            wr_en = first_fits;
          end
          OP_WHEEL: begin
            wr_en   = first_fits;
            wr_data = wheel_color(wheel_q);
          end
          OP_FILL: begin
            // A reversed range or one that starts past the strip writes nothing.
            if (first_fits && (first_q <= last_q)) begin
              sweep_ctrl.load = 1'b1;
              state_d         = ST_SWEEP;
            end
          end
          OP_FILL_OFF: begin
            sweep_ctrl.load = 1'b1;
            state_d         = ST_SWEEP;
          end
          OP_CLEAR: begin
            clr_all    = 1'b1;
            emit_pix_d = '0;
            emit_bit_d = '0;
          end
          OP_EMIT: begin
            rd_en   = 1'b1;
            state_d = ST_EMIT;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx;
        // Others-off fill blanks every pixel outside the range.
        if ((op_q == OP_FILL_OFF) && !sweep_stat.in_range) begin
          wr_data = '0;
        end
        if (sweep_stat.at_end) begin
          state_d = ST_IDLE;
        end else begin
          sweep_ctrl.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          if (emit_bit_q == LAST_BIT) begin
            emit_bit_d = '0;
            emit_pix_d = (emit_pix_q == LAST_IDX) ? '0 : emit_pix_q + 1'b1;
          end else begin
            emit_bit_d = emit_bit_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      emit_pix_q <= '0;
      emit_bit_q <= '0;
      m_valid_q  <= 1'b0;
      one_pat_q  <= ONE_PAT_RST;
      zero_pat_q <= ZERO_PAT_RST;
      op_q       <= OP_SET;
    end else begin
      state_q    <= state_d;
      emit_pix_q <= emit_pix_d;
      emit_bit_q <= emit_bit_d;
      m_valid_q  <= m_valid_d;
      if (accept) begin
        op_q <= op_e'(s_tuser_i);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ONE_PAT:  one_pat_q  <= cfg_data_i;
          CFG_ZERO_PAT: zero_pat_q <= cfg_data_i;
          default:      one_pat_q  <= one_pat_q;
        endcase
      end
    end
  end

  // Request payload and output data carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q <= s_tdata_i[7:0];
      last_q  <= s_tdata_i[15:8];
      color_q <= s_tdata_i[39:16];
      wheel_q <= s_tdata_i[47:40];
    end
    if (load_out) begin
      m_data_q <= pix_bit ? one_pat_q : zero_pat_q;
      m_last_q <= frame_end;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;

  lsfe_pixel_store #(
    .DEPTH (STRIP_LENGTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .clr_i     (clr_all),
    .rd_en_i   (rd_en),
    .rd_addr_i (emit_pix_q),
    .rd_data_o (rd_data)
  );

  lsfe_sweep_unit #(
    .IDX_W (IDX_W)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sweep_ctrl),
    .start_i (sweep_start),
    .stop_i  (sweep_stop),
    .lo_i    (first_q),
    .hi_i    (last_q),
    .idx_o   (sweep_idx),
    .stat_o  (sweep_stat)
  );

endmodule
